[src/mset_pkg.sv]
package mset_pkg;

  // Fixed field widths of the request and result channels.
  localparam int unsigned FuncW  = 2;
  localparam int unsigned IdW    = 16;
  localparam int unsigned EvW    = 32;
  localparam int unsigned TickW  = 64;
  localparam int unsigned RoomW  = 5;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CountW = 5;

  // Most events one process request may emit.
  localparam logic [RoomW-1:0] EventCap = RoomW'(16);

  // Operation codes.
  localparam logic [FuncW-1:0] FuncStart   = 2'd0;
  localparam logic [FuncW-1:0] FuncRestart = 2'd1;
  localparam logic [FuncW-1:0] FuncCancel  = 2'd2;
  localparam logic [FuncW-1:0] FuncProcess = 2'd3;

  // Status codes.
  localparam logic [StatW-1:0] StOk       = 3'd0;
  localparam logic [StatW-1:0] StOverflow = 3'd1;
  localparam logic [StatW-1:0] StExists   = 3'd2;
  localparam logic [StatW-1:0] StFull     = 3'd3;
  localparam logic [StatW-1:0] StNotFound = 3'd4;
  localparam logic [StatW-1:0] StBlocked  = 3'd5;

endpackage

[src/multi_slot_event_timer.sv]
// Channel | valid      | stall       | payload
// request | in_valid_i | in_stall_o  | func_i timer_id_i event_data_i now_i delay_i period_i room_i
// result  | out_valid_o| out_stall_i | is_event_o .. last_o
//
// Start, restart and cancel take a scan of the slots, an update, a second
// scan for the earliest deadline and a load of the status result.
// A process request walks the slots once and then scans them again for the
// earliest deadline; each fired periodic slot adds a 64-step remainder
// division in the shared divider.
// Reset clears all slots at once. The request side stalls while a request is
// in work; a stalled result holds the sequencer until it is taken.
module multi_slot_event_timer #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mset_pkg::FuncW-1:0]    func_i,
  input  logic [mset_pkg::IdW-1:0]      timer_id_i,
  input  logic [mset_pkg::EvW-1:0]      event_data_i,
  input  logic [mset_pkg::TickW-1:0]    now_i,
  input  logic [mset_pkg::TickW-1:0]    delay_i,
  input  logic [mset_pkg::TickW-1:0]    period_i,
  input  logic [mset_pkg::RoomW-1:0]    room_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          is_event_o,
  output logic [mset_pkg::EvW-1:0]      fired_payload_o,
  output logic [mset_pkg::IdW-1:0]      fired_id_o,
  output logic [mset_pkg::StatW-1:0]    status_o,
  output logic [mset_pkg::RoomW-1:0]    emitted_o,
  output logic [mset_pkg::CountW-1:0]   active_count_o,
  output logic [mset_pkg::TickW-1:0]    next_deadline_o,
  output logic                          deadline_valid_o,
  output logic                          last_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned TW = mset_pkg::TickW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIND  = 4'd1;
  localparam logic [3:0] S_APPLY = 4'd2;
  localparam logic [3:0] S_PROC  = 4'd3;
  localparam logic [3:0] S_EMIT  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_BASE  = 4'd6;
  localparam logic [3:0] S_ADV   = 4'd7;
  localparam logic [3:0] S_MIN   = 4'd8;
  localparam logic [3:0] S_STAT  = 4'd9;

  // Slot table.
  logic [SLOTS-1:0]               act_q;
  logic [mset_pkg::IdW-1:0]       sid_q [SLOTS];
  logic [mset_pkg::EvW-1:0]       spay_q[SLOTS];
  logic [TW-1:0]                  sdl_q [SLOTS];
  logic [TW-1:0]                  sper_q[SLOTS];
  logic [CW-1:0]                  cnt_q;

  // Sequencer and latched request.
  logic [3:0]                     state_q;
  logic [IW:0]                    idx_q;
  logic [mset_pkg::FuncW-1:0]     func_q;
  logic [mset_pkg::IdW-1:0]       id_q;
  logic [mset_pkg::EvW-1:0]       pay_q;
  logic [TW-1:0]                  now_q;
  logic [TW-1:0]                  delay_q;
  logic [TW-1:0]                  per_q;
  logic [mset_pkg::RoomW-1:0]     room_q;
  logic [mset_pkg::RoomW-1:0]     em_q;
  logic [mset_pkg::StatW-1:0]     st_q;
  logic                           hit_q;
  logic [IW-1:0]                  hit_idx_q;
  logic                           free_q;
  logic [IW-1:0]                  free_idx_q;
  logic [TW-1:0]                  nd_q;
  logic                           nv_q;

  // Shared divider: remainder of dvd by the slot period.
  logic [TW-1:0]                  dvd_q;
  logic [TW-1:0]                  rem_q;
  logic [TW-1:0]                  base_q;
  logic [6:0]                     step_q;

  // Result register.
  logic                           ov_q;
  logic                           o_ev_q;
  logic [mset_pkg::EvW-1:0]       o_pay_q;
  logic [mset_pkg::IdW-1:0]       o_id_q;
  logic [mset_pkg::StatW-1:0]     o_st_q;
  logic [mset_pkg::RoomW-1:0]     o_em_q;
  logic [mset_pkg::CountW-1:0]    o_cnt_q;
  logic [TW-1:0]                  o_nd_q;
  logic                           o_nv_q;
  logic                           o_last_q;

  logic [IW-1:0]                  ix;
  logic                           idx_end;
  logic                           out_free;
  logic                           out_load;
  logic                           cur_act;
  logic [TW-1:0]                  cur_dl;
  logic [TW:0]                    sum_ovf;
  logic [TW:0]                    rem_sh;
  logic [TW:0]                    rem_sub;
  logic [TW:0]                    adv_sum;
  logic [mset_pkg::RoomW-1:0]     room_sat;

  // Slot at the scan position.
  assign ix       = idx_q[IW-1:0];
  assign idx_end  = (idx_q == (IW+1)'(SLOTS - 1));
  assign cur_act  = act_q[ix];
  assign cur_dl   = sdl_q[ix];
  assign out_free = !ov_q || !out_stall_i;
  assign out_load = out_free && ((state_q == S_EMIT) || (state_q == S_STAT));
  assign sum_ovf  = {1'b0, now_q} + {1'b0, delay_q};
  assign rem_sh   = {rem_q, dvd_q[TW-1]};
  assign rem_sub  = rem_sh - {1'b0, sper_q[ix]};
  assign adv_sum  = {1'b0, base_q} + {1'b0, sper_q[ix]};
  assign room_sat = (room_i > mset_pkg::EventCap) ? mset_pkg::EventCap : room_i;

  assign in_stall_o = (state_q != S_IDLE);

  // Sequencer, table and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      idx_q   <= '0;
    end else begin
      // The result register fills from an event or status load and empties when taken.
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            func_q  <= func_i;
            id_q    <= timer_id_i;
            pay_q   <= event_data_i;
            now_q   <= now_i;
            delay_q <= delay_i;
            per_q   <= period_i;
            room_q  <= room_sat;
            em_q    <= '0;
            st_q    <= mset_pkg::StOk;
            hit_q   <= 1'b0;
            free_q  <= 1'b0;
            idx_q   <= '0;
            state_q <= (func_i == mset_pkg::FuncProcess) ? S_PROC : S_FIND;
          end
        end
        S_FIND: begin
          // First active slot with the id, and first free slot.
          if (cur_act && sid_q[ix] == id_q && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= ix;
          end
          if (!cur_act && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= ix;
          end
          idx_q <= idx_q + 1'b1;
          if (idx_end) begin
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          idx_q   <= '0;
          nv_q    <= 1'b0;
          nd_q    <= '0;
          state_q <= S_MIN;
          if (func_q == mset_pkg::FuncCancel) begin
            if (!hit_q) begin
              st_q <= mset_pkg::StNotFound;
            end else begin
              act_q[hit_idx_q] <= 1'b0;
              cnt_q <= cnt_q - 1'b1;
            end
          end else if (sum_ovf[TW]) begin
            st_q <= mset_pkg::StOverflow;
          end else if (func_q == mset_pkg::FuncStart) begin
            if (hit_q) begin
              st_q <= mset_pkg::StExists;
            end else if (!free_q) begin
              st_q <= mset_pkg::StFull;
            end else begin
              act_q[free_idx_q]  <= 1'b1;
              sid_q[free_idx_q]  <= id_q;
              spay_q[free_idx_q] <= pay_q;
              sdl_q[free_idx_q]  <= sum_ovf[TW-1:0];
              sper_q[free_idx_q] <= per_q;
              cnt_q <= cnt_q + 1'b1;
            end
          end else if (!hit_q) begin
            st_q <= mset_pkg::StNotFound;
          end else begin
            sid_q[hit_idx_q]  <= id_q;
            spay_q[hit_idx_q] <= pay_q;
            sdl_q[hit_idx_q]  <= sum_ovf[TW-1:0];
            sper_q[hit_idx_q] <= per_q;
          end
        end
        S_PROC: begin
          // Look at one slot; a due slot either fires or blocks the walk.
          if (idx_q == (IW+1)'(SLOTS)) begin
            idx_q   <= '0;
            nv_q    <= 1'b0;
            nd_q    <= '0;
            state_q <= S_MIN;
          end else if (!cur_act || now_q < cur_dl) begin
            idx_q <= idx_q + 1'b1;
          end else if (em_q >= room_q) begin
            st_q    <= mset_pkg::StBlocked;
            idx_q   <= '0;
            nv_q    <= 1'b0;
            nd_q    <= '0;
            state_q <= S_MIN;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            o_ev_q   <= 1'b1;
            o_pay_q  <= spay_q[ix];
            o_id_q   <= sid_q[ix];
            o_st_q   <= mset_pkg::StOk;
            o_em_q   <= '0;
            o_cnt_q  <= '0;
            o_nd_q   <= '0;
            o_nv_q   <= 1'b0;
            o_last_q <= 1'b0;
            em_q     <= em_q + 1'b1;
            if (sper_q[ix] == '0) begin
              act_q[ix] <= 1'b0;
              cnt_q     <= cnt_q - 1'b1;
              idx_q     <= idx_q + 1'b1;
              state_q   <= S_PROC;
            end else begin
              dvd_q   <= now_q - cur_dl;
              rem_q   <= '0;
              step_q  <= '0;
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // One restoring step per cycle; only the remainder is kept.
          rem_q  <= rem_sub[TW] ? rem_sh[TW-1:0] : rem_sub[TW-1:0];
          dvd_q  <= {dvd_q[TW-2:0], 1'b0};
          step_q <= step_q + 1'b1;
          if (step_q == 7'(TW - 1)) begin
            state_q <= S_BASE;
          end
        end
        S_BASE: begin
          base_q  <= now_q - rem_q;
          state_q <= S_ADV;
        end
        S_ADV: begin
          // New deadline is the last period boundary at or before now, plus one period; on overflow the slot is freed.
          if (adv_sum[TW]) begin
            act_q[ix] <= 1'b0;
            cnt_q     <= cnt_q - 1'b1;
          end else begin
            sdl_q[ix] <= adv_sum[TW-1:0];
          end
          idx_q   <= idx_q + 1'b1;
          state_q <= S_PROC;
        end
        S_MIN: begin
          // Earliest deadline among active slots.
          if (cur_act && (!nv_q || cur_dl < nd_q)) begin
            nd_q <= cur_dl;
            nv_q <= 1'b1;
          end
          idx_q <= idx_q + 1'b1;
          if (idx_end) begin
            state_q <= S_STAT;
          end
        end
        S_STAT: begin
          if (out_free) begin
            o_ev_q   <= 1'b0;
            o_pay_q  <= '0;
            o_id_q   <= '0;
            o_st_q   <= st_q;
            o_em_q   <= em_q;
            o_cnt_q  <= mset_pkg::CountW'(cnt_q);
            o_nd_q   <= nd_q;
            o_nv_q   <= nv_q;
            o_last_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = ov_q;
  assign is_event_o       = o_ev_q;
  assign fired_payload_o  = o_pay_q;
  assign fired_id_o       = o_id_q;
  assign status_o         = o_st_q;
  assign emitted_o        = o_em_q;
  assign active_count_o   = o_cnt_q;
  assign next_deadline_o  = o_nd_q;
  assign deadline_valid_o = o_nv_q;
  assign last_o           = o_last_q;

endmodule
